// File: src/rrs_pkg.sv
// Package for the response ratio scheduler: sizes, commands, task states,
// controller status/command structs. No dependencies.
`default_nettype none
package rrs_pkg;
    localparam int NumSlots    = 64;
    localparam int TimeBits    = 32;
    localparam int ChanBits    = 8;
    localparam int SlotBits    = 6;
    localparam int WeightBits  = 48;
    localparam int ShiftBits   = 5;
    localparam logic [ShiftBits-1:0] ShiftReset = 5'd8;
    localparam logic [WeightBits-1:0] WMax = {WeightBits{1'b1}};

    localparam logic [2:0] CMD_ADMIT  = 3'd0;
    localparam logic [2:0] CMD_SCHED  = 3'd1;
    localparam logic [2:0] CMD_YIELD  = 3'd2;
    localparam logic [2:0] CMD_SLEEP  = 3'd3;
    localparam logic [2:0] CMD_WAKEUP = 3'd4;
    localparam logic [2:0] CMD_FREE   = 3'd5;

    localparam logic [1:0] ST_UNUSED   = 2'd0;
    localparam logic [1:0] ST_RUNNABLE = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_SLEEPING = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, start table scan
        logic rd;        // issue read of current scan slot
        logic exec;      // apply the command to the read slot
        logic div_start; // start ratio unit
        logic div_take;  // compare ratio against best
        logic finish;    // commit result and pick
        logic step;      // advance scan index
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last; // current slot is the last
        logic need_div;  // schedule on a runnable slot with exec nonzero
        logic div_done;
        logic multi;     // command walks all slots
    } t_ctl_sts;
endpackage
`default_nettype wire

// File: src/response_ratio_scheduler.sv
// Highest-response-ratio-next task scheduler over a 64-slot task table.
// One request is taken at a time and gives exactly one response. Admit,
// yield, sleep and free touch one slot. Schedule and wakeup walk all 64
// slots through the single-port table memory; schedule, while no task runs,
// adds for each runnable slot with nonzero exec time one pass of the
// bit-serial ratio divider (63 quotient bits). The response sits in an
// output register; a new request is taken once the previous response has
// been loaded into it.
// Depends on rrs_pkg, rrs_ctrl, rrs_datapath, rrs_ratio.
`default_nettype none
module response_ratio_scheduler
    import rrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [2:0]            i_cmd,
    input  wire logic [SlotBits-1:0]   i_slot,
    input  wire logic [ChanBits-1:0]   i_channel,
    input  wire logic [TimeBits-1:0]   i_now,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [SlotBits-1:0]        o_chosen_slot,
    output logic                       o_chosen_valid,
    output logic [WeightBits-1:0]      o_chosen_weight,
    output logic                       o_status,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [ShiftBits-1:0]  i_cfg_data
);
    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;
    logic busy, start, out_free;
    logic [ShiftBits-1:0] r_shift;
    logic [SlotBits-1:0]  d_slot;
    logic                 d_cvalid, d_status;
    logic [WeightBits-1:0] d_weight;

    // ratio_shift register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_shift <= ShiftReset;
        else if (i_cfg_valid) r_shift <= i_cfg_data;
    end

    assign o_stall  = busy;
    assign start    = i_valid && !busy;
    assign out_free = !o_valid || !i_stall;

    rrs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_out_free(out_free), .i_sts(ctl_sts), .o_cmd(ctl_cmd), .o_busy(busy)
    );

    rrs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(ctl_cmd), .i_op(i_cmd),
        .i_slot(i_slot), .i_channel(i_channel), .i_now(i_now),
        .i_shift(r_shift), .o_sts(ctl_sts), .o_chosen_slot(d_slot),
        .o_chosen_valid(d_cvalid), .o_chosen_weight(d_weight),
        .o_status(d_status)
    );

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (ctl_cmd.finish) o_valid <= 1'b1;
        else if (!i_stall) o_valid <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (ctl_cmd.finish) begin
            o_chosen_slot   <= d_slot;
            o_chosen_valid  <= d_cvalid;
            o_chosen_weight <= d_weight;
            o_status        <= d_status;
        end
    end

    a_one_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.finish |-> out_free) else $error("response overwritten");
    a_chosen_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chosen_valid |-> !o_status) else $error("pick with reject");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.load |-> !busy) else $error("load while busy");
endmodule
`default_nettype wire

// File: src/rrs_ctrl.sv
// Controller FSM of the response ratio scheduler.
// Depends on rrs_pkg.
`default_nettype none
module rrs_ctrl
    import rrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_out_free,
    input  t_ctl_sts      i_sts,
    output t_ctl_cmd      o_cmd,
    output logic          o_busy
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EXEC = 3'd2,
                           S_DIV = 3'd3, S_NEXT = 3'd4, S_DONE = 3'd5;
    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else if (!i_sts.multi || i_sts.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = i_sts.scan_last ? S_DONE : S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.step = 1'b1;
                n_state = S_RD;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

// File: src/rrs_ratio.sv
// Iterative ratio unit: (1<<sh) + floor((wt<<sh)/ex), saturated to 48 bits.
// One quotient bit per cycle, ex nonzero. Depends on rrs_pkg.
`default_nettype none
module rrs_ratio
    import rrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [TimeBits-1:0]   i_ex,
    input  wire logic [TimeBits-1:0]   i_wt,
    input  wire logic [ShiftBits-1:0]  i_sh,
    output logic                       o_done,
    output logic [WeightBits-1:0]      o_weight
);
    // long division of the (TimeBits+sh)-bit dividend, MSB first
    localparam int DivBits = TimeBits + 31;
    localparam int CntBits = $clog2(DivBits + 1);
    logic [DivBits-1:0]    r_num;
    logic [TimeBits-1:0]   r_den;
    logic [TimeBits:0]     r_rem;
    logic [DivBits-1:0]    r_quo;
    logic [CntBits-1:0]    r_cnt;
    logic [ShiftBits-1:0]  r_sh;
    logic                  r_busy, r_done;
    logic [TimeBits:0]     rem_sh;
    logic                  ge;
    logic [DivBits:0]      sum;

    assign rem_sh = {r_rem[TimeBits-1:0], r_num[DivBits-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= DivBits'({i_wt, 31'd0} >> (5'd31 - i_sh));
                r_den  <= i_ex;
                r_rem  <= '0;
                r_quo  <= '0;
                r_sh   <= i_sh;
                r_cnt  <= CntBits'(DivBits);
            end else if (r_busy) begin
                r_num <= {r_num[DivBits-2:0], 1'b0};
                r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
                r_quo <= {r_quo[DivBits-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign sum = {1'b0, r_quo} + ((DivBits+1)'(1) << r_sh);
    assign o_done = r_done;
    always_comb begin
        if (sum[DivBits:WeightBits] != '0) o_weight = WMax;
        else o_weight = sum[WeightBits-1:0];
    end
endmodule
`default_nettype wire

// File: src/rrs_datapath.sv
// Datapath: task table memory, command execution, best-ratio tracking.
// Depends on rrs_pkg and rrs_ratio.
`default_nettype none
module rrs_datapath
    import rrs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  t_ctl_cmd                   i_cmd,
    input  wire logic [2:0]            i_op,
    input  wire logic [SlotBits-1:0]   i_slot,
    input  wire logic [ChanBits-1:0]   i_channel,
    input  wire logic [TimeBits-1:0]   i_now,
    input  wire logic [ShiftBits-1:0]  i_shift,
    output t_ctl_sts                   o_sts,
    output logic [SlotBits-1:0]        o_chosen_slot,
    output logic                       o_chosen_valid,
    output logic [WeightBits-1:0]      o_chosen_weight,
    output logic                       o_status
);
    typedef struct packed {
        logic [1:0]          st;
        logic [TimeBits-1:0] ex;
        logic [TimeBits-1:0] wt;
        logic [TimeBits-1:0] rs;
        logic [TimeBits-1:0] run;
        logic [ChanBits-1:0] ch;
    } t_entry;

    // valid bits kept in flops (64 of them), rest of each entry, state included, in a memory
    logic [NumSlots-1:0]  r_used;
    t_entry               mem [NumSlots];
    t_entry               r_rd, ent_rd, wr_ent;
    logic                 wr_en;
    logic [SlotBits-1:0]  r_idx, wr_idx;

    logic [2:0]           r_op;
    logic [ChanBits-1:0]  r_ch;
    logic [TimeBits-1:0]  r_now;
    logic                 r_run_valid;
    logic [SlotBits-1:0]  r_run_slot;
    logic                 r_found, r_status;
    logic [SlotBits-1:0]  r_pick;
    logic [WeightBits-1:0] r_best;
    logic                 div_done;
    logic [WeightBits-1:0] div_w;
    logic [TimeBits:0]    wsum, esum;
    logic [TimeBits-1:0]  wt_new, ex_new;
    logic                 multi;

    assign multi = (r_op == CMD_SCHED) || (r_op == CMD_WAKEUP);
    assign ent_rd = r_used[r_idx] ? r_rd : '0;
    assign wsum = {1'b0, ent_rd.wt} + {1'b0, r_now - ent_rd.rs};
    assign wt_new = wsum[TimeBits] ? '1 : wsum[TimeBits-1:0];
    assign esum = {1'b0, ent_rd.ex} + {1'b0, r_now - ent_rd.run};
    assign ex_new = esum[TimeBits] ? '1 : esum[TimeBits-1:0];

    assign o_sts.scan_last = (r_idx == SlotBits'(NumSlots - 1));
    assign o_sts.multi = multi;
    assign o_sts.need_div = (r_op == CMD_SCHED) && !r_run_valid &&
                            (ent_rd.st == ST_RUNNABLE) && (ent_rd.ex != '0);
    assign o_sts.div_done = div_done;

    rrs_ratio u_ratio (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_ex(ent_rd.ex), .i_wt(wt_new), .i_sh(i_shift),
        .o_done(div_done), .o_weight(div_w)
    );

    // command effect on the slot just read
    always_comb begin
        wr_en = 1'b0;
        wr_idx = r_idx;
        wr_ent = ent_rd;
        case (r_op)
            CMD_ADMIT: begin
                wr_en = (ent_rd.st == ST_UNUSED);
                wr_ent = '0;
                wr_ent.st = ST_RUNNABLE;
                wr_ent.rs = r_now;
            end
            CMD_SCHED: begin
                wr_en = !r_run_valid && (ent_rd.st == ST_RUNNABLE);
                wr_ent.wt = wt_new;
                wr_ent.rs = r_now;
            end
            CMD_YIELD, CMD_SLEEP: begin
                wr_en = r_run_valid;
                wr_ent.ex = ex_new;
                if (r_op == CMD_YIELD) begin
                    wr_ent.st = ST_RUNNABLE;
                    wr_ent.rs = r_now;
                end else begin
                    wr_ent.st = ST_SLEEPING;
                    wr_ent.ch = r_ch;
                end
            end
            CMD_WAKEUP: begin
                wr_en = (ent_rd.st == ST_SLEEPING) && (ent_rd.ch == r_ch);
                wr_ent.st = ST_RUNNABLE;
                wr_ent.rs = r_now;
            end
            CMD_FREE: begin
                wr_en = (ent_rd.st != ST_UNUSED);
                wr_ent = '0;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= mem[r_idx];
        if (i_cmd.exec && wr_en) mem[wr_idx] <= wr_ent;
        if (i_cmd.finish && r_found) begin
            mem[r_pick].st  <= ST_RUNNING;
            mem[r_pick].run <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_run_valid <= 1'b0;
            r_run_slot <= '0;
        end else begin
            if (i_cmd.exec && wr_en) r_used[wr_idx] <= 1'b1;
            if (i_cmd.finish) begin
                if (r_op == CMD_SCHED && r_found) begin
                    r_run_valid <= 1'b1;
                    r_run_slot <= r_pick;
                end else if ((r_op == CMD_YIELD || r_op == CMD_SLEEP) && r_run_valid) begin
                    r_run_valid <= 1'b0;
                end else if (r_op == CMD_FREE && !r_status && r_run_slot == r_idx) begin
                    r_run_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_ch <= i_channel;
            r_now <= i_now;
            r_found <= 1'b0;
            r_best <= '0;
            r_pick <= '0;
            r_idx <= (i_op == CMD_YIELD || i_op == CMD_SLEEP) ? r_run_slot :
                     (i_op == CMD_SCHED || i_op == CMD_WAKEUP) ? '0 : i_slot;
        end
        if (i_cmd.step) r_idx <= r_idx + 1'b1;
        if (i_cmd.exec) begin
            case (r_op)
                CMD_ADMIT:  r_status <= (ent_rd.st != ST_UNUSED);
                CMD_SCHED:  r_status <= r_run_valid;
                CMD_YIELD, CMD_SLEEP: r_status <= !r_run_valid;
                CMD_WAKEUP: r_status <= 1'b0;
                CMD_FREE:   r_status <= (ent_rd.st == ST_UNUSED);
                default:    r_status <= 1'b1;
            endcase
            // exec zero: greatest weight, no division needed
            if (r_op == CMD_SCHED && !r_run_valid && ent_rd.st == ST_RUNNABLE &&
                ent_rd.ex == '0 && (!r_found || WMax > r_best)) begin
                r_found <= 1'b1;
                r_best <= WMax;
                r_pick <= r_idx;
            end
        end
        if (i_cmd.div_take && (!r_found || div_w > r_best)) begin
            r_found <= 1'b1;
            r_best <= div_w;
            r_pick <= r_idx;
        end
    end

    assign o_chosen_valid  = (r_op == CMD_SCHED) && !r_status && r_found;
    assign o_chosen_slot   = o_chosen_valid ? r_pick : '0;
    assign o_chosen_weight = o_chosen_valid ? r_best : '0;
    assign o_status        = r_status;
endmodule
`default_nettype wire
